### src/vcm_pkg.sv
// Shared types and constants for the volume centroid block.
package vcm_pkg;

  // Width of each centroid result field.
  localparam int unsigned OUT_BITS = 24;

  // Width of the size registers and of the register address.
  localparam int unsigned SIZE_BITS = 9;
  localparam int unsigned ADDR_BITS = 4;

  // Size registers come out of reset at 256 voxels per side.
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 9'd256;

  // Register indexes, taken from the word address.
  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2,
    REG_SIGNED = 2'd3
  } reg_index_t;

  // Configuration seen by the accumulator.
  typedef struct packed {
    logic [SIZE_BITS-1:0] size_x;
    logic [SIZE_BITS-1:0] size_y;
    logic [SIZE_BITS-1:0] size_z;
    logic                 signed_samples;
  } cfg_t;

  // Divider sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_DIV,
    BK_FIN,
    BK_DONE
  } back_state_t;

endpackage

### src/volume_center_of_mass_top.sv
// Top level of the volume centroid block: register file, accumulator, queue and divider.
//
// Voxel requests enter on push/full, one per cycle, in raster order (x fastest, then y,
// then z); sample is read as unsigned or two's complement by the signed register.
// After the last voxel of a volume one result request appears on the result side:
// centroids as signed fixed point with FRACTION_BITS fraction bits, truncated toward
// zero and saturated, plus the zero-total and clipped flags. Take it with pop while
// empty is low.
// Throughput: one voxel per cycle while the volume streams in and full is low. Each
// volume's result comes from a shared restoring divider that makes one quotient bit
// per cycle over MOMENT_W + FRACTION_BITS bits, for x, y and z in turn.
// Finished sums wait in a two-entry queue, so the next volume streams in while the
// divider works. full rises only when a last voxel cannot hand its sums to a full
// queue, which happens with volumes shorter than the divide time or with pop held low.
// A stalled result sits in the result register; the divider then holds its next result.
// Reset (synchronous, active high) clears all sums, positions and pending results and
// sets the sizes to 256 per side with unsigned samples. Size and mode registers are
// written over the APB-style port at byte address 4 * index.
module volume_center_of_mass_top #(
  parameter int unsigned MAX_SIDE      = 256,
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [vcm_pkg::ADDR_BITS-1:0]        paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  // Voxel input.
  input  logic                                 push,
  output logic                                 full,
  input  logic [SAMPLE_BITS-1:0]               sample,
  // Result output.
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [vcm_pkg::OUT_BITS-1:0]  centroid_x,
  output logic signed [vcm_pkg::OUT_BITS-1:0]  centroid_y,
  output logic signed [vcm_pkg::OUT_BITS-1:0]  centroid_z,
  output logic                                 zero_total,
  output logic                                 clipped
);

  localparam int unsigned CW          = $clog2(MAX_SIDE);
  localparam int unsigned TOTAL_W     = SAMPLE_BITS + 3 * CW + 2;
  localparam int unsigned MOMENT_W    = TOTAL_W + CW;
  localparam int unsigned SNAP_W      = 3 * MOMENT_W + TOTAL_W;
  localparam int unsigned QUEUE_DEPTH = 2;

  vcm_pkg::cfg_t       cfg;
  vcm_pkg::reg_index_t reg_idx;
  logic                cfg_wr;

  logic              q_push, q_full, q_pop, q_empty;
  logic [SNAP_W-1:0] q_wr_data, q_rd_data;

  // Register file.
  assign pready  = 1'b1;
  assign reg_idx = vcm_pkg::reg_index_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_x         <= vcm_pkg::SIZE_RESET;
      cfg.size_y         <= vcm_pkg::SIZE_RESET;
      cfg.size_z         <= vcm_pkg::SIZE_RESET;
      cfg.signed_samples <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        vcm_pkg::REG_SIZE_X: cfg.size_x         <= pwdata[vcm_pkg::SIZE_BITS-1:0];
        vcm_pkg::REG_SIZE_Y: cfg.size_y         <= pwdata[vcm_pkg::SIZE_BITS-1:0];
        vcm_pkg::REG_SIZE_Z: cfg.size_z         <= pwdata[vcm_pkg::SIZE_BITS-1:0];
        vcm_pkg::REG_SIGNED: cfg.signed_samples <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      vcm_pkg::REG_SIZE_X: prdata = 32'(cfg.size_x);
      vcm_pkg::REG_SIZE_Y: prdata = 32'(cfg.size_y);
      vcm_pkg::REG_SIZE_Z: prdata = 32'(cfg.size_z);
      vcm_pkg::REG_SIGNED: prdata = 32'(cfg.signed_samples);
      default:             prdata = '0;
    endcase
  end

  // Accumulator.
  vcm_front #(
    .MAX_SIDE    (MAX_SIDE),
    .SAMPLE_BITS (SAMPLE_BITS),
    .TOTAL_W     (TOTAL_W),
    .MOMENT_W    (MOMENT_W)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .push   (push),
    .full   (full),
    .sample (sample),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  // Queue of finished volume sums.
  vcm_fifo #(
    .WIDTH (SNAP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // Divider and result register.
  vcm_back #(
    .TOTAL_W       (TOTAL_W),
    .MOMENT_W      (MOMENT_W),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (q_rd_data),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .centroid_x (centroid_x),
    .centroid_y (centroid_y),
    .centroid_z (centroid_z),
    .zero_total (zero_total),
    .clipped    (clipped)
  );

`ifndef ASSERT_OFF
  // The accumulator never hands sums to a full queue.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("volume sums pushed into a full queue");

  // A zero-total result carries zero centroids and no clip flag.
  a_zero_total_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && zero_total) |-> (centroid_x == '0 && centroid_y == '0 &&
                                centroid_z == '0 && !clipped))
    else $error("zero-total result with nonzero fields");

  // Reset leaves no pending result and an open input.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("result or stall pending after reset");
`endif

endmodule

### src/vcm_front.sv
// Voxel accumulator: raster position tracking and moment sums.
module vcm_front #(
  parameter int unsigned MAX_SIDE    = 256,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned TOTAL_W     = 42,
  parameter int unsigned MOMENT_W    = 50
) (
  input  logic                          clk,
  input  logic                          rst,
  input  vcm_pkg::cfg_t                 cfg,
  input  logic                          push,
  output logic                          full,
  input  logic [SAMPLE_BITS-1:0]        sample,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [3*MOMENT_W+TOTAL_W-1:0] q_data
);

  localparam int unsigned CW = $clog2(MAX_SIDE);
  localparam int unsigned VW = SAMPLE_BITS + 1;
  localparam int unsigned PW = CW + VW + 1;

  // Index of the last voxel along an axis, with the size clamped to 1..MAX_SIDE.
  function automatic logic [CW-1:0] last_index(input logic [vcm_pkg::SIZE_BITS-1:0] sz);
    if (sz == '0) begin
      return '0;
    end
    if (32'(sz) > MAX_SIDE) begin
      return CW'(MAX_SIDE - 1);
    end
    return CW'(sz - 1'b1);
  endfunction

  logic [CW-1:0]        pos_x, pos_y, pos_z;
  logic                 last_x, last_y, last_z;
  logic                 accept;
  logic signed [VW-1:0] v_ext;

  logic                 b_valid;
  logic                 b_end;
  logic signed [VW-1:0] b_v;
  logic [CW-1:0]        b_px, b_py, b_pz;
  logic                 b_adv;

  logic signed [PW-1:0]       prod_x, prod_y, prod_z;
  logic signed [MOMENT_W-1:0] acc_x, acc_y, acc_z;
  logic signed [MOMENT_W-1:0] sum_x, sum_y, sum_z;
  logic signed [TOTAL_W-1:0]  acc_t, sum_t;

  // Position of the incoming voxel against the current extents.
  assign last_x = pos_x >= last_index(cfg.size_x);
  assign last_y = pos_y >= last_index(cfg.size_y);
  assign last_z = pos_z >= last_index(cfg.size_z);

  // The accumulate stage only holds when it must hand a finished volume to a full queue.
  assign b_adv  = b_valid && !(b_end && q_full);
  assign full   = b_valid && b_end && q_full;
  assign accept = push && !full;

  // Sample widened by one bit, sign extended in signed mode.
  assign v_ext = {cfg.signed_samples & sample[SAMPLE_BITS-1], sample};

  // Raster counters: x fastest, then y, then z.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (accept) begin
      if (!last_x) begin
        pos_x <= pos_x + 1'b1;
      end else begin
        pos_x <= '0;
        if (!last_y) begin
          pos_y <= pos_y + 1'b1;
        end else begin
          pos_y <= '0;
          if (!last_z) begin
            pos_z <= pos_z + 1'b1;
          end else begin
            pos_z <= '0;
          end
        end
      end
    end
  end

  // Register stage between the input and the multiply-accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_v   <= v_ext;
      b_px  <= pos_x;
      b_py  <= pos_y;
      b_pz  <= pos_z;
      b_end <= last_x && last_y && last_z;
    end
  end

  // Coordinate times sample, one multiplier per axis.
  assign prod_x = $signed({1'b0, b_px}) * b_v;
  assign prod_y = $signed({1'b0, b_py}) * b_v;
  assign prod_z = $signed({1'b0, b_pz}) * b_v;

  assign sum_x = acc_x + {{(MOMENT_W-PW){prod_x[PW-1]}}, prod_x};
  assign sum_y = acc_y + {{(MOMENT_W-PW){prod_y[PW-1]}}, prod_y};
  assign sum_z = acc_z + {{(MOMENT_W-PW){prod_z[PW-1]}}, prod_z};
  assign sum_t = acc_t + {{(TOTAL_W-VW){b_v[VW-1]}}, b_v};

  // Running sums; cleared once the last voxel's sums go to the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_x <= '0;
      acc_y <= '0;
      acc_z <= '0;
      acc_t <= '0;
    end else if (b_adv) begin
      if (b_end) begin
        acc_x <= '0;
        acc_y <= '0;
        acc_z <= '0;
        acc_t <= '0;
      end else begin
        acc_x <= sum_x;
        acc_y <= sum_y;
        acc_z <= sum_z;
        acc_t <= sum_t;
      end
    end
  end

  assign q_push = b_adv && b_end;
  assign q_data = {sum_z, sum_y, sum_x, sum_t};

endmodule

### src/vcm_fifo.sv
// Small register queue that carries finished volume sums to the divider.
module vcm_fifo #(
  parameter int unsigned WIDTH = 192,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr_en, rd_en;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign wr_en   = push && !full;
  assign rd_en   = pop && !empty;
  assign rd_data = slots[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/vcm_back.sv
// Centroid divider: one quotient bit per cycle, three axes in turn, with result register.
module vcm_back #(
  parameter int unsigned TOTAL_W       = 42,
  parameter int unsigned MOMENT_W      = 50,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_empty,
  input  logic [3*MOMENT_W+TOTAL_W-1:0]        q_data,
  output logic                                 q_pop,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [vcm_pkg::OUT_BITS-1:0]  centroid_x,
  output logic signed [vcm_pkg::OUT_BITS-1:0]  centroid_y,
  output logic signed [vcm_pkg::OUT_BITS-1:0]  centroid_z,
  output logic                                 zero_total,
  output logic                                 clipped
);

  localparam int unsigned OW = vcm_pkg::OUT_BITS;
  localparam int unsigned NW = MOMENT_W + FRACTION_BITS;
  localparam int unsigned SW = $clog2(NW);
  localparam logic [1:0]  LAST_AXIS = 2'd2;

  vcm_pkg::back_state_t state, state_next;

  logic [TOTAL_W-1:0]  q_total;
  logic [TOTAL_W-1:0]  t_abs;
  logic [MOMENT_W-1:0] mom0, mom1, mom2;
  logic [MOMENT_W-1:0] m_abs;
  logic                m_neg;
  logic [TOTAL_W-1:0]  at;
  logic                tneg;
  logic [NW-1:0]       num;
  logic [TOTAL_W:0]    rem, shifted, rem_next;
  logic                fits;
  logic [OW-1:0]       quo, limit, mag, signed_val;
  logic                ovf, neg, sat;
  logic [SW-1:0]       step;
  logic [1:0]          axis;
  logic [OW-1:0]       res_x, res_y, res_z;
  logic                clip_acc, zt;
  logic                out_valid, out_load;

  // Magnitudes of the dequeued total and of the moment under division.
  assign q_total = q_data[TOTAL_W-1:0];
  assign t_abs   = q_total[TOTAL_W-1] ? (~q_total + 1'b1) : q_total;
  assign m_neg   = mom0[MOMENT_W-1];
  assign m_abs   = m_neg ? (~mom0 + 1'b1) : mom0;

  // Restoring division step.
  assign shifted  = {rem[TOTAL_W-1:0], num[NW-1]};
  assign fits     = shifted >= {1'b0, at};
  assign rem_next = fits ? (shifted - {1'b0, at}) : shifted;

  // Saturate the magnitude and apply the sign.
  assign limit      = neg ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
  assign sat        = ovf || (quo > limit);
  assign mag        = sat ? limit : quo;
  assign signed_val = neg ? (~mag + 1'b1) : mag;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vcm_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshakes.
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      vcm_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = (q_total == '0) ? vcm_pkg::BK_DONE : vcm_pkg::BK_LOAD;
        end
      end
      vcm_pkg::BK_LOAD: begin
        state_next = vcm_pkg::BK_DIV;
      end
      vcm_pkg::BK_DIV: begin
        if (step == '0) begin
          state_next = vcm_pkg::BK_FIN;
        end
      end
      vcm_pkg::BK_FIN: begin
        state_next = (axis == LAST_AXIS) ? vcm_pkg::BK_DONE : vcm_pkg::BK_LOAD;
      end
      vcm_pkg::BK_DONE: begin
        if (!out_valid || pop) begin
          out_load   = 1'b1;
          state_next = vcm_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = vcm_pkg::BK_IDLE;
      end
    endcase
  end

  // Divider datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      vcm_pkg::BK_IDLE: begin
        if (!q_empty) begin
          mom0     <= q_data[TOTAL_W +: MOMENT_W];
          mom1     <= q_data[TOTAL_W+MOMENT_W +: MOMENT_W];
          mom2     <= q_data[TOTAL_W+2*MOMENT_W +: MOMENT_W];
          at       <= t_abs;
          tneg     <= q_total[TOTAL_W-1];
          axis     <= '0;
          clip_acc <= 1'b0;
          zt       <= q_total == '0;
          res_x    <= '0;
          res_y    <= '0;
          res_z    <= '0;
        end
      end
      vcm_pkg::BK_LOAD: begin
        num  <= NW'(m_abs) << FRACTION_BITS;
        rem  <= '0;
        quo  <= '0;
        ovf  <= 1'b0;
        neg  <= m_neg ^ tneg;
        step <= SW'(NW - 1);
      end
      vcm_pkg::BK_DIV: begin
        num  <= num << 1;
        rem  <= rem_next;
        quo  <= {quo[OW-2:0], fits};
        ovf  <= ovf | quo[OW-1];
        step <= step - 1'b1;
      end
      vcm_pkg::BK_FIN: begin
        // Results shift in from z so that x lands last in place.
        res_z    <= signed_val;
        res_y    <= res_z;
        res_x    <= res_y;
        mom0     <= mom1;
        mom1     <= mom2;
        clip_acc <= clip_acc | sat;
        axis     <= axis + 1'b1;
      end
      vcm_pkg::BK_DONE: begin
        if (out_load) begin
          centroid_x <= res_x;
          centroid_y <= res_y;
          centroid_z <= res_z;
          zero_total <= zt;
          clipped    <= clip_acc;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register; a new result may be loaded in the cycle the old one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && !pop) || out_load;
    end
  end

  assign empty = !out_valid;

endmodule
